// ===== rtl/bblm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblm_pkg
// Shared types, codes and the per-step mixing operation of the byte box mixer.
// ----------------------------------------------------------------------------
package bblm_pkg;

  localparam int MAX_BOX_BYTES_DEF = 256;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int BOXLEN_W = 9;
  localparam int MULT_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MIX   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Result kinds
  localparam logic KIND_MIX  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MULT = 1'b1;

  // Step number (mod 64) that runs the whole-box pass instead of an operation
  localparam logic [5:0] BLOOM_STEP = 6'd17;

  // Read address source
  typedef enum logic [1:0] {
    RD_IN,
    RD_I,
    RD_J,
    RD_P
  } rd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    wr_byte;
    logic    rd_issue;
    rd_sel_t rd_sel;
    logic    hold_load;
    logic    rem_init;
    logic    rem_step;
    logic    op_wr;
    logic    step_adv;
    logic    bl_init;
    logic    bl_wr;
    logic    p_init;
    logic    z_wr;
    logic    out_load;
    logic    out_kind;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rem_last;
    logic no_steps;
    logic step_last;
    logic step_bloom;
    logic p_last;
    logic out_free;
  } dp_stat_t;

  // One mixing operation selected by step number mod 64, truncated to 8 bits
  function automatic logic [7:0] mix_op(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] i);
    logic [15:0] a16;
    logic [15:0] b16;
    logic [15:0] i16;
    logic [15:0] r;
    logic [3:0]  s8;
    logic [3:0]  s4;
    a16 = {8'd0, a};
    b16 = {8'd0, b};
    i16 = {8'd0, i};
    s8  = {1'b0, i[2:0]};
    s4  = {2'b00, i[1:0]};
    case (i[5:0])
      6'd0:  r = a16 ^ b16;
      6'd1:  r = a16 & b16;
      6'd2:  r = ~(a16 & b16);
      6'd3:  r = ~(a16 | b16);
      6'd4:  r = a16 | b16;
      6'd5:  r = a16 ^ b16;
      6'd6:  r = a16 & ~b16;
      6'd7:  r = b16 & ~a16;
      6'd8:  r = (a16 << 1) | (a16 >> 7);
      6'd9:  r = (b16 >> 1) | (b16 << 7);
      6'd10: r = ~(a16 ^ b16);
      6'd11: r = a16 + b16;
      6'd12: r = a16 - b16;
      6'd13: r = (a16 | b16) ^ (a16 & b16);
      6'd14: r = (a16 >> 2) | (b16 << 6);
      6'd15: r = a16 ^ (b16 << 1);
      6'd16: r = (a16 & b16) | (a16 ^ b16);
      6'd18: r = ~a16 ^ b16;
      6'd19: r = a16 * 16'd3 + b16 * 16'd7;
      6'd20: r = (a16 << 3) ^ (b16 >> 2);
      6'd21: r = (a16 + 16'd1) ^ (b16 - 16'd1);
      6'd22: r = (a16 ^ 16'h21) & b16;
      6'd23: r = (b16 * b16) ^ a16;
      6'd24: r = ~(a16 >> 1) + (b16 << 2);
      6'd25: r = (a16 | b16) << 1;
      6'd26: r = ((a16 & 16'h4A) << 4) | ((b16 & 16'h2D) >> 4);
      6'd27: r = a16 * b16 + i16;
      6'd28: r = (a16 << s8) | (b16 >> (4'd8 - s8));
      6'd29: r = (b16 << 2) - (a16 >> 1);
      6'd30: r = (a16 ^ b16 ^ i16) + 16'd42;
      6'd31: r = (a16 & b16) ^ 16'h5A;
      6'd32: r = (a16 ^ 16'h3C) + (b16 ^ 16'hC3);
      6'd33: r = ~(a16 ^ b16) + i16;
      6'd34: r = a16 + (b16 ^ 16'h33);
      6'd35: r = (a16 >> 3) + (b16 << 5);
      6'd36: r = (a16 * 16'd13) ^ (b16 * 16'd17);
      6'd37: r = (a16 | ~b16) + 16'd91;
      6'd38: r = a16 ^ b16 ^ (i16 * 16'd31);
      6'd39: r = (a16 & b16 & i16) | (a16 ^ b16);
      6'd40: r = (a16 << 2) ^ (b16 >> 2);
      6'd41: r = (a16 + b16 + i16) * 16'd7;
      6'd42: r = (a16 | i16) ^ (b16 & i16);
      6'd43: r = (a16 & b16) + (a16 | b16);
      6'd44: r = ((a16 + b16) >> 1) ^ a16;
      6'd45: r = (a16 * b16) ^ (a16 + b16);
      6'd46: r = (a16 * 16'd2 + b16 * 16'd3) ^ i16;
      6'd47: r = ((a16 & 16'h21) | (b16 & 16'h55)) ^ i16;
      6'd48: r = (a16 << 1) + (b16 << 2);
      6'd49: r = a16 * a16 - b16 * b16;
      6'd50: r = ((a16 ^ b16) >> 1) + 16'd128;
      6'd51: r = ((a16 & b16) << 1) | (a16 ^ b16);
      6'd52: r = a16 ^ b16 ^ 16'h5B;
      6'd53: r = ((a16 + 16'd13) * (b16 + 16'd29)) >> 2;
      6'd54: r = (a16 * 16'd11) ^ (b16 * 16'd19 + i16);
      6'd55: r = ((a16 << 1) | (b16 >> 1)) ^ i16;
      6'd56: r = (a16 & b16) ^ (~a16 | b16);
      6'd57: r = (a16 + b16 + i16) ^ (a16 * b16);
      6'd58: r = ((a16 >> 1) + (b16 << 1)) ^ i16;
      6'd59: r = (a16 ^ b16) + i16 * 16'd37;
      6'd60: r = (~a16 & b16) | (a16 & ~b16);
      6'd61: r = a16 ^ ((b16 + i16) * 16'd5);
      6'd62: r = (a16 << s4) ^ (b16 >> s4);
      default: r = ((a16 ^ i16) + b16 * 16'd2) >> 1;
    endcase
    return r[7:0];
  endfunction

endpackage

// ===== rtl/bblm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblm_in_if
// Command channel of the byte box mixer: one item per accepted handshake.
// ----------------------------------------------------------------------------
interface bblm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] byte_index;
  logic [7:0] write_byte;

  modport source (output valid, output cmd, output byte_index, output write_byte,
                  input ready);
  modport sink   (input valid, input cmd, input byte_index, input write_byte,
                  output ready);
endinterface

// ===== rtl/bblm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblm_out_if
// Result channel of the byte box mixer: one item per accepted handshake.
// ----------------------------------------------------------------------------
interface bblm_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] read_byte;

  modport source (output valid, output result_kind, output read_byte, input ready);
  modport sink   (input valid, input result_kind, input read_byte, output ready);
endinterface

// ===== rtl/bblm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblm_ctrl
// Sequencer of the byte box mixer: command decode, mix steps and sweeps.
// ----------------------------------------------------------------------------
module bblm_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_cmd,
  output logic                    in_ready,
  input  bblm_pkg::dp_stat_t      stat,
  output bblm_pkg::ctrl_cmd_t     cmd
);
  import bblm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_REM,
    S_A,
    S_B,
    S_OP,
    S_BL_RD,
    S_BL_WR,
    S_Z_RD,
    S_Z_WR,
    S_FIN_RD,
    S_FIN_MIX
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode state into datapath commands and pick the next state
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IN;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE: cmd.wr_byte = 1'b1;
            CMD_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RD;
            end
            CMD_MIX: begin
              cmd.rem_init = 1'b1;
              state_nxt    = S_REM;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        cmd.hold_load = 1'b1;
        state_nxt     = S_FIN_RD;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (stat.rem_last) begin
          if (stat.no_steps) begin
            cmd.p_init = 1'b1;
            state_nxt  = S_Z_RD;
          end else begin
            state_nxt = S_A;
          end
        end
      end
      S_A: begin
        cmd.rd_sel = RD_I;
        state_nxt  = S_B;
      end
      S_B: begin
        cmd.rd_sel    = RD_J;
        cmd.hold_load = 1'b1;
        state_nxt     = S_OP;
      end
      S_OP: begin
        if (stat.step_bloom) begin
          cmd.bl_init = 1'b1;
          state_nxt   = S_BL_RD;
        end else begin
          cmd.op_wr    = 1'b1;
          cmd.step_adv = 1'b1;
          if (stat.step_last) begin
            cmd.p_init = 1'b1;
            state_nxt  = S_Z_RD;
          end else begin
            state_nxt = S_A;
          end
        end
      end
      S_BL_RD: begin
        cmd.rd_sel = RD_P;
        state_nxt  = S_BL_WR;
      end
      S_BL_WR: begin
        cmd.bl_wr = 1'b1;
        if (stat.p_last) begin
          cmd.step_adv = 1'b1;
          if (stat.step_last) begin
            cmd.p_init = 1'b1;
            state_nxt  = S_Z_RD;
          end else begin
            state_nxt = S_A;
          end
        end else begin
          state_nxt = S_BL_RD;
        end
      end
      S_Z_RD: begin
        cmd.rd_sel = RD_P;
        state_nxt  = S_Z_WR;
      end
      S_Z_WR: begin
        cmd.z_wr  = 1'b1;
        state_nxt = stat.p_last ? S_FIN_MIX : S_Z_RD;
      end
      S_FIN_RD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_READ;
          state_nxt    = S_IDLE;
        end
      end
      S_FIN_MIX: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_MIX;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bblm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblm_dp
// Datapath of the byte box mixer: box memory, configuration, step and partner
// index, modulo unit, sweep counter and output register.
// ----------------------------------------------------------------------------
module bblm_dp #(
  parameter int MAX_BOX_BYTES = bblm_pkg::MAX_BOX_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              in_byte_index,
  input  logic [7:0]              in_write_byte,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_idx,
  input  logic [31:0]             cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_result_kind,
  output logic [7:0]              out_read_byte,
  input  bblm_pkg::ctrl_cmd_t     cmd,
  output bblm_pkg::dp_stat_t      stat
);
  import bblm_pkg::*;

  localparam int AW = (MAX_BOX_BYTES > 1) ? $clog2(MAX_BOX_BYTES) : 1;
  localparam int LW = $clog2(MAX_BOX_BYTES + 1);

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] s);
    logic [15:0] d;
    d = {v, v} << s;
    return d[15:8];
  endfunction

  // Configuration and working registers
  logic [BOXLEN_W-1:0] box_len_r;
  logic [MULT_W-1:0]   mult_r;
  logic [7:0]          i_r;
  logic [LW-1:0]       j_r;
  logic [LW-1:0]       rem_r;
  logic [4:0]          bitcnt_r;
  logic [LW-1:0]       p_r;
  logic [7:0]          m_r;
  logic [7:0]          a_r;
  logic                oob_r;
  logic [7:0]          rdata_r;
  logic                out_valid_r;
  logic                out_kind_r;
  logic [7:0]          out_byte_r;

  logic [7:0]          box_mem [MAX_BOX_BYTES];

  logic [LW-1:0]       len_c;
  logic [LW-1:0]       half_c;
  logic                in_range;
  logic [LW:0]         rem_try;
  logic [LW-1:0]       rem_nxt;
  logic [LW:0]         j_sum;
  logic [LW-1:0]       j_nxt;
  logic [7:0]          op_val;
  logic [7:0]          bl_x;
  logic [15:0]         bl_prod;
  logic [7:0]          bl_val;
  logic [7:0]          z_try;
  logic [7:0]          z_val;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic [AW-1:0]       mem_raddr;

  // Effective length: zero counts as one, clamp to the store size
  always_comb begin
    if (box_len_r == '0) begin
      len_c = LW'(1);
    end else if (32'(box_len_r) > MAX_BOX_BYTES) begin
      len_c = LW'(MAX_BOX_BYTES);
    end else begin
      len_c = LW'(box_len_r);
    end
  end
  assign half_c   = len_c >> 1;
  assign in_range = (32'(in_byte_index) < MAX_BOX_BYTES);

  // Restoring remainder of the multiplier by the length, one bit per cycle
  assign rem_try = {rem_r, mult_r[bitcnt_r]};
  assign rem_nxt = (rem_try >= {1'b0, len_c}) ? LW'(rem_try - {1'b0, len_c})
                                              : LW'(rem_try);

  // Advance partner index by the remainder, wrap once
  assign j_sum = {1'b0, j_r} + {1'b0, rem_r};
  assign j_nxt = (j_sum >= {1'b0, len_c}) ? LW'(j_sum - {1'b0, len_c}) : LW'(j_sum);

  // Step operation, whole-box pass and zero replacement values
  assign op_val  = mix_op(a_r, rdata_r, i_r);
  assign bl_x    = rdata_r ^ rotl8(m_r, 3'(p_r));
  assign bl_prod = 16'(bl_x) * 16'd33;
  assign bl_val  = bl_prod[7:0] ^ (m_r + 8'(p_r));
  assign z_try   = 8'(8'(p_r) * 8'd31 + 8'd1);
  assign z_val   = (z_try == '0) ? 8'd1 : z_try;

  // Status to the controller
  assign stat.rem_last   = (bitcnt_r == '0);
  assign stat.no_steps   = (half_c == '0);
  assign stat.step_last  = (({1'b0, i_r} + 9'd1) >= half_c);
  assign stat.step_bloom = (i_r[5:0] == BLOOM_STEP);
  assign stat.p_last     = (p_r == LW'(len_c - LW'(1)));
  assign stat.out_free   = !out_valid_r || out_ready;

  // Memory port select
  always_comb begin
    case (cmd.rd_sel)
      RD_I:    mem_raddr = AW'(i_r);
      RD_J:    mem_raddr = AW'(j_r);
      RD_P:    mem_raddr = AW'(p_r);
      default: mem_raddr = AW'(in_byte_index);
    endcase
    mem_we    = 1'b0;
    mem_waddr = AW'(p_r);
    mem_wdata = bl_val;
    if (cmd.wr_byte) begin
      mem_we    = in_range;
      mem_waddr = AW'(in_byte_index);
      mem_wdata = in_write_byte;
    end else if (cmd.op_wr) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(i_r);
      mem_wdata = op_val;
    end else if (cmd.bl_wr) begin
      mem_we = 1'b1;
    end else if (cmd.z_wr) begin
      mem_we    = (rdata_r == '0);
      mem_wdata = z_val;
    end
  end

  // Box memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      box_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= box_mem[mem_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_len_r <= BOXLEN_W'(256);
      mult_r    <= MULT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        CFG_BOX_LENGTH: box_len_r <= cfg_wdata[BOXLEN_W-1:0];
        CFG_INDEX_MULT: mult_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Step, partner, remainder and sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      j_r      <= '0;
      rem_r    <= '0;
      bitcnt_r <= '0;
      p_r      <= '0;
    end else begin
      if (cmd.rem_init) begin
        i_r      <= '0;
        j_r      <= '0;
        rem_r    <= '0;
        bitcnt_r <= 5'd31;
      end else if (cmd.rem_step) begin
        rem_r    <= rem_nxt;
        bitcnt_r <= bitcnt_r - 5'd1;
      end else if (cmd.step_adv) begin
        i_r <= i_r + 8'd1;
        j_r <= j_nxt;
      end
      if (cmd.p_init || cmd.bl_init) begin
        p_r <= '0;
      end else if (cmd.bl_wr || cmd.z_wr) begin
        p_r <= p_r + LW'(1);
      end
    end
  end

  // Operand, out-of-range flag and bloom seed capture
  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      a_r <= rdata_r;
    end
    if (cmd.rd_issue) begin
      oob_r <= !in_range;
    end
    if (cmd.bl_init) begin
      m_r <= (a_r ^ rdata_r) + (a_r | rdata_r);
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_byte_r <= (cmd.out_kind == KIND_READ && !oob_r) ? a_r : 8'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_read_byte   = out_byte_r;

endmodule

// ===== rtl/byte_box_logic_mixer_unit.sv =====
`timescale 1ns / 1ps
// Write: stored when accepted. Read: the byte passes the memory read register,
// the operand register and the output register, which waits until free. Mix:
// the multiplier remainder, then per step over half the length S_A, S_B, S_OP,
// a read and a write per byte in each whole-box pass and in the zero pass, and
// the output register; one item at a time.
// Reset (synchronous, rst_n low) clears control and configuration; the box store
// is not cleared and holds no valid data until written.
// ----------------------------------------------------------------------------
// byte_box_logic_mixer_unit
// Top level: controller, datapath and the channel interfaces.
// ----------------------------------------------------------------------------
module byte_box_logic_mixer_unit #(
  parameter int MAX_BOX_BYTES = bblm_pkg::MAX_BOX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bblm_in_if.sink            in_ch,
  bblm_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic               cfg_idx,
  input  logic [31:0]        cfg_wdata
);
  import bblm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer
  bblm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Box memory and arithmetic
  bblm_dp #(
    .MAX_BOX_BYTES (MAX_BOX_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte_index   (in_ch.byte_index),
    .in_write_byte   (in_ch.write_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_kind (out_ch.result_kind),
    .out_read_byte   (out_ch.read_byte),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
